[design/bead_spring_pair_energy_top_macros.svh]
// assertion macros shared by the checker of the bead pair energy block
// expects clk and arst_n to be visible where a macro is used
`ifndef BEAD_SPRING_PAIR_ENERGY_TOP_MACROS_SVH
`define BEAD_SPRING_PAIR_ENERGY_TOP_MACROS_SVH

// same-cycle implication
`define BSPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/bspe_pkg.sv]
// types, codes and constants of the bead pair energy pipeline
// no dependencies; used by the datapath, the top level and the checker
package bspe_pkg;

	localparam int MAX_BEADS = 1024;

	// pipeline stage numbers
	localparam int ST_DIFF     = 2;
	localparam int ST_SQ       = 3;
	localparam int ST_SUM      = 4;
	localparam int ST_IT_FIRST = 5;
	localparam int ST_IT_LAST  = 14;
	localparam int ST_BD       = 15;
	localparam int ST_Q2       = 16;
	localparam int ST_MUL3     = 17;
	localparam int ST_U        = 18;
	localparam int ST_T        = 19;
	localparam int ST_UT       = 20;
	localparam int ST_P        = 21;
	localparam int ST_PE       = 22;
	localparam int ST_MAG      = 23;
	localparam int ST_LAST     = 24;

	// iteration steps done by one stage of the divider and the root unit
	localparam int IT_PER_STAGE = 4;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_BOND = 2'd1;
	localparam logic [1:0] KIND_WCA  = 2'd2;
	localparam logic [1:0] KIND_LJ   = 2'd3;

	localparam logic [1:0] REG_BEADS_PER_CHAIN  = 2'd0;
	localparam logic [1:0] REG_SPRING_K         = 2'd1;
	localparam logic [1:0] REG_BOND_REST_LENGTH = 2'd2;
	localparam logic [1:0] REG_LJ_WELL_DEPTH    = 2'd3;

	localparam logic [47:0] E_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] E_MIN = 48'h8000_0000_0000;

	localparam logic [65:0] WCA_CUT_Q32 = 66'd5411319705;
	localparam logic [65:0] LJ_CUT_Q32  = 66'h10_0000_0000;
	localparam logic [65:0] LJ_NEAR_Q32 = 66'h100_0000;
	localparam logic [35:0] DIV_START   = 36'h100_0000;
	localparam logic [55:0] ONE_Q32     = 56'h1_0000_0000;

	typedef struct packed {
		logic [10:0] beads_per_chain;
		logic [23:0] spring_k;
		logic [23:0] bond_rest_length;
		logic [23:0] lj_well_depth;
	} cfg_t;

	typedef struct packed {
		logic [9:0]       first_index;
		logic [9:0]       second_index;
		logic [2:0][31:0] c1;
		logic [2:0][31:0] c2;
	} in_item_t;

	typedef struct packed {
		logic [9:0]       first_index;
		logic [9:0]       second_index;
		logic [2:0][31:0] c1;
		logic [2:0][31:0] c2;
		logic [2:0][31:0] dmag;
		logic [2:0][63:0] sq;
		logic             order_ok;
		logic [9:0]       gap;
		logic [10:0]      cmod;
		logic [1:0]       kind;
		logic [65:0]      r2;
		logic             in_wca;
		logic             in_lj;
		logic             near;
		logic [35:0]      dv_rem;
		logic [39:0]      quo;
		logic [34:0]      sr_rem;
		logic [32:0]      root;
		logic [32:0]      bd;
		logic [65:0]      bdd;
		logic [56:0]      bp_lo;
		logic [56:0]      bp_hi;
		logic [46:0]      bond_e;
		logic             bond_sat;
		logic [39:0]      qhh;
		logic [39:0]      qhl;
		logic [39:0]      qll;
		logic [47:0]      q2;
		logic [63:0]      mhi;
		logic [63:0]      mlo;
		logic [55:0]      u;
		logic [55:0]      t;
		logic             neg;
		logic [3:0][55:0] ut;
		logic [79:0]      pv;
		logic [2:0][50:0] pe;
		logic [46:0]      lj_mag;
		logic             lj_ovf;
		logic [47:0]      energy;
		logic             sat;
	} pipe_t;

endpackage

[design/bspe_datapath.sv]
// pair energy pipeline: distance, chain test, root and reciprocal units, products
// depends on bspe_pkg
module bspe_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  bspe_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  bspe_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [47:0]       energy,
	output logic [1:0]        kind,
	output logic              sat
);

	bspe_pkg::pipe_t pipe_s [1:bspe_pkg::ST_LAST];
	logic [bspe_pkg::ST_LAST:1] vld_s;
	logic [bspe_pkg::ST_LAST:1] en;
	bspe_pkg::pipe_t ld;

	function automatic bspe_pkg::pipe_t stage_step(input int s, input bspe_pkg::pipe_t cur,
			input bspe_pkg::cfg_t c);
		bspe_pkg::pipe_t n;
		logic [10:0] cl;
		logic signed [32:0] dif;
		logic signed [32:0] dneg;
		logic [11:0] msh;
		logic [66:0] rsum;
		logic same1;
		logic same2;
		logic [36:0] dsh;
		logic [36:0] ssh;
		logic [36:0] trial;
		logic [80:0] qsum;
		logic [88:0] msum;
		logic [90:0] bsum;
		logic [112:0] psum;
		logic [104:0] asum;
		logic signed [48:0] lj_val;
		logic signed [48:0] esum;
		logic [47:0] lj_sat_e;
		int i;
		int j;
		int tt;
		int k;
		n = cur;
		cl = (c.beads_per_chain == '0) ? 11'd1 : c.beads_per_chain;
		case (s)
			bspe_pkg::ST_DIFF: begin
				for (i = 0; i < 3; i++) begin
					dif = $signed({cur.c1[i][31], cur.c1[i]}) - $signed({cur.c2[i][31], cur.c2[i]});
					dneg = -dif;
					n.dmag[i] = dif[32] ? dneg[31:0] : dif[31:0];
				end
				n.order_ok = (cur.second_index > cur.first_index)
					&& (32'(cur.second_index) < 32'(bspe_pkg::MAX_BEADS));
				n.gap = cur.second_index - cur.first_index;
				n.cmod = '0;
				// first half of the remainder of first_index by chain length
				for (i = 9; i >= 5; i--) begin
					msh = {n.cmod, cur.first_index[i]};
					if (msh >= {1'b0, cl}) begin
						msh = msh - {1'b0, cl};
					end
					n.cmod = msh[10:0];
				end
			end
			bspe_pkg::ST_SQ: begin
				for (i = 0; i < 3; i++) begin
					n.sq[i] = 64'(cur.dmag[i]) * 64'(cur.dmag[i]);
				end
				for (i = 4; i >= 0; i--) begin
					msh = {n.cmod, cur.first_index[i]};
					if (msh >= {1'b0, cl}) begin
						msh = msh - {1'b0, cl};
					end
					n.cmod = msh[10:0];
				end
			end
			bspe_pkg::ST_SUM: begin
				rsum = 67'(cur.sq[0]) + 67'(cur.sq[1]) + 67'(cur.sq[2]);
				n.r2 = rsum[65:0];
				n.in_wca = rsum[65:0] < bspe_pkg::WCA_CUT_Q32;
				n.in_lj = rsum[65:0] < bspe_pkg::LJ_CUT_Q32;
				n.near = rsum[65:0] <= bspe_pkg::LJ_NEAR_Q32;
				// same chain when the offset inside the chain plus the gap stays in it
				same1 = (12'(cur.cmod) + 12'd1) < 12'(cl);
				same2 = (12'(cur.cmod) + 12'd2) < 12'(cl);
				if (!cur.order_ok) begin
					n.kind = bspe_pkg::KIND_NONE;
				end else if (cur.gap == 10'd1) begin
					n.kind = same1 ? bspe_pkg::KIND_BOND : bspe_pkg::KIND_NONE;
				end else if (cur.gap == 10'd2) begin
					n.kind = same2 ? bspe_pkg::KIND_WCA : bspe_pkg::KIND_NONE;
				end else begin
					n.kind = bspe_pkg::KIND_LJ;
				end
				n.dv_rem = bspe_pkg::DIV_START;
				n.quo = '0;
				n.sr_rem = '0;
				n.root = '0;
			end
			bspe_pkg::ST_BD: begin
				n.bd = (cur.root >= 33'(c.bond_rest_length))
					? cur.root - 33'(c.bond_rest_length)
					: 33'(c.bond_rest_length) - cur.root;
				n.qhh = 40'(cur.quo[39:20]) * 40'(cur.quo[39:20]);
				n.qhl = 40'(cur.quo[39:20]) * 40'(cur.quo[19:0]);
				n.qll = 40'(cur.quo[19:0]) * 40'(cur.quo[19:0]);
			end
			bspe_pkg::ST_Q2: begin
				n.bdd = 66'(cur.bd) * 66'(cur.bd);
				qsum = (81'(cur.qhh) << 40) + (81'(cur.qhl) << 21) + 81'(cur.qll);
				n.q2 = qsum[79:32];
			end
			bspe_pkg::ST_MUL3: begin
				n.bp_lo = 57'(cur.bdd[32:0]) * 57'(c.spring_k);
				n.bp_hi = 57'(cur.bdd[65:33]) * 57'(c.spring_k);
				n.mhi = 64'(cur.q2[47:24]) * 64'(cur.quo);
				n.mlo = 64'(cur.q2[23:0]) * 64'(cur.quo);
			end
			bspe_pkg::ST_U: begin
				bsum = 91'(cur.bp_lo) + (91'(cur.bp_hi) << 33);
				n.bond_sat = |bsum[90:80];
				n.bond_e = bsum[79:33];
				msum = (89'(cur.mhi) << 24) + 89'(cur.mlo);
				n.u = msum[87:32];
			end
			bspe_pkg::ST_T: begin
				n.neg = cur.u < bspe_pkg::ONE_Q32;
				n.t = (cur.u < bspe_pkg::ONE_Q32) ? bspe_pkg::ONE_Q32 - cur.u
					: cur.u - bspe_pkg::ONE_Q32;
			end
			bspe_pkg::ST_UT: begin
				n.ut[0] = 56'(cur.u[55:28]) * 56'(cur.t[55:28]);
				n.ut[1] = 56'(cur.u[55:28]) * 56'(cur.t[27:0]);
				n.ut[2] = 56'(cur.u[27:0]) * 56'(cur.t[55:28]);
				n.ut[3] = 56'(cur.u[27:0]) * 56'(cur.t[27:0]);
			end
			bspe_pkg::ST_P: begin
				psum = (113'(cur.ut[0]) << 56) + (113'(cur.ut[1]) << 28)
					+ (113'(cur.ut[2]) << 28) + 113'(cur.ut[3]);
				n.pv = psum[111:32];
			end
			bspe_pkg::ST_PE: begin
				n.pe[0] = 51'(cur.pv[26:0]) * 51'(c.lj_well_depth);
				n.pe[1] = 51'(cur.pv[53:27]) * 51'(c.lj_well_depth);
				n.pe[2] = 51'(cur.pv[79:54]) * 51'(c.lj_well_depth);
			end
			bspe_pkg::ST_MAG: begin
				asum = 105'(cur.pe[0]) + (105'(cur.pe[1]) << 27) + (105'(cur.pe[2]) << 54);
				n.lj_ovf = |asum[104:77];
				n.lj_mag = asum[76:30];
			end
			bspe_pkg::ST_LAST: begin
				lj_val = cur.neg ? -$signed({2'b00, cur.lj_mag}) : $signed({2'b00, cur.lj_mag});
				lj_sat_e = cur.neg ? bspe_pkg::E_MIN : bspe_pkg::E_MAX;
				n.energy = '0;
				n.sat = 1'b0;
				case (cur.kind)
					bspe_pkg::KIND_BOND: begin
						n.sat = cur.bond_sat;
						n.energy = cur.bond_sat ? bspe_pkg::E_MAX : {1'b0, cur.bond_e};
					end
					bspe_pkg::KIND_WCA: begin
						if (cur.in_wca && (c.lj_well_depth != '0)) begin
							if (cur.near) begin
								n.sat = 1'b1;
								n.energy = bspe_pkg::E_MAX;
							end else if (cur.lj_ovf) begin
								n.sat = 1'b1;
								n.energy = lj_sat_e;
							end else begin
								// shift up by epsilon, then clip
								esum = lj_val + $signed({25'b0, c.lj_well_depth});
								if (!esum[48] && esum[47]) begin
									n.sat = 1'b1;
									n.energy = bspe_pkg::E_MAX;
								end else if (esum[48] && !esum[47]) begin
									n.sat = 1'b1;
									n.energy = bspe_pkg::E_MIN;
								end else begin
									n.energy = esum[47:0];
								end
							end
						end
					end
					bspe_pkg::KIND_LJ: begin
						if (cur.in_lj && (c.lj_well_depth != '0)) begin
							if (cur.near) begin
								n.sat = 1'b1;
								n.energy = bspe_pkg::E_MAX;
							end else if (cur.lj_ovf) begin
								n.sat = 1'b1;
								n.energy = lj_sat_e;
							end else begin
								n.energy = lj_val[47:0];
							end
						end
					end
					default: begin
						n.energy = '0;
					end
				endcase
			end
			default: begin
				// shared iteration stages: reciprocal divider and square root
				if (s >= bspe_pkg::ST_IT_FIRST && s <= bspe_pkg::ST_IT_LAST) begin
					j = s - bspe_pkg::ST_IT_FIRST;
					for (tt = 0; tt < bspe_pkg::IT_PER_STAGE; tt++) begin
						dsh = {n.dv_rem, 1'b0};
						if (dsh >= 37'(n.r2[35:0])) begin
							dsh = dsh - 37'(n.r2[35:0]);
							n.quo = {n.quo[38:0], 1'b1};
						end else begin
							n.quo = {n.quo[38:0], 1'b0};
						end
						n.dv_rem = dsh[35:0];
						k = 32 - (bspe_pkg::IT_PER_STAGE * j + tt);
						if (k >= 0) begin
							ssh = {n.sr_rem, n.r2[2 * k +: 2]};
							trial = 37'({n.root, 2'b01});
							if (ssh >= trial) begin
								ssh = ssh - trial;
								n.root = {n.root[31:0], 1'b1};
							end else begin
								n.root = {n.root[31:0], 1'b0};
							end
							n.sr_rem = ssh[34:0];
						end
					end
				end
			end
		endcase
		return n;
	endfunction

	// stage enables: a stage moves when it is empty or the one after it moves
	assign en[bspe_pkg::ST_LAST] = !vld_s[bspe_pkg::ST_LAST] || !out_stall;
	for (genvar g = 1; g < bspe_pkg::ST_LAST; g++) begin : g_en
		assign en[g] = !vld_s[g] || en[g + 1];
	end

	assign in_stall = !en[1];

	always_comb begin
		ld = '0;
		ld.first_index = in_item.first_index;
		ld.second_index = in_item.second_index;
		ld.c1 = in_item.c1;
		ld.c2 = in_item.c2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int v = 2; v <= bspe_pkg::ST_LAST; v++) begin
				if (en[v]) begin
					vld_s[v] <= vld_s[v - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pipe_s[1] <= ld;
		end
	end

	for (genvar g = 2; g <= bspe_pkg::ST_LAST; g++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en[g]) begin
				pipe_s[g] <= stage_step(g, pipe_s[g - 1], cfg);
			end
		end
	end

	assign out_valid = vld_s[bspe_pkg::ST_LAST];
	assign energy = pipe_s[bspe_pkg::ST_LAST].energy;
	assign kind = pipe_s[bspe_pkg::ST_LAST].kind;
	assign sat = pipe_s[bspe_pkg::ST_LAST].sat;

endmodule

[design/bead_spring_pair_energy_top.sv]
// top level of the bead pair energy block: configuration registers and the pipeline
// depends on bspe_pkg and bspe_datapath
//
//  channel  handshake              payload
//  in       in_valid / in_stall    first_index, second_index, first_x..z, second_x..z
//  out      out_valid / out_stall  pair_energy, pair_kind, saturated
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one pair per cycle while out_stall does not hold the pipeline
// the pipeline has 24 register stages, ten of them for the root and reciprocal units
// reset clears the valid bits and loads the configuration defaults
// out_stall freezes only full stages: bubbles close up and the input keeps flowing while a stage is empty
// cfg_ready is always high; registers are to be written by the user only while no pair is in flight (not enforced)
module bead_spring_pair_energy_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [9:0]         first_index,
	input  logic [9:0]         second_index,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] second_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] pair_energy,
	output logic [1:0]         pair_kind,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	// configuration registers
	bspe_pkg::cfg_t cfg_q;
	bspe_pkg::in_item_t in_item;
	logic [47:0] energy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beads_per_chain <= 11'd10;
			cfg_q.spring_k <= 24'd655360;
			cfg_q.bond_rest_length <= 24'd65536;
			cfg_q.lj_well_depth <= 24'd1310720;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bspe_pkg::REG_BEADS_PER_CHAIN: cfg_q.beads_per_chain <= cfg_data[10:0];
				bspe_pkg::REG_SPRING_K: cfg_q.spring_k <= cfg_data;
				bspe_pkg::REG_BOND_REST_LENGTH: cfg_q.bond_rest_length <= cfg_data;
				bspe_pkg::REG_LJ_WELL_DEPTH: cfg_q.lj_well_depth <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input transfer payload, coordinates kept as raw two's complement bits
	always_comb begin
		in_item.first_index = first_index;
		in_item.second_index = second_index;
		in_item.c1[0] = first_x;
		in_item.c1[1] = first_y;
		in_item.c1[2] = first_z;
		in_item.c2[0] = second_x;
		in_item.c2[1] = second_y;
		in_item.c2[2] = second_z;
	end

	bspe_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.energy    (energy),
		.kind      (pair_kind),
		.sat       (saturated)
	);

	assign pair_energy = $signed(energy);

endmodule

[design/bspe_checker.sv]
// port-level checks of the bead pair energy block, bound to the top level
// depends on bspe_pkg and the assertion macros header
`include "bead_spring_pair_energy_top_macros.svh"

module bspe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [47:0] pair_energy,
	input logic [1:0]         pair_kind,
	input logic               saturated
);

	`BSPE_ASSERT_NOW(a_none_is_zero, out_valid && (pair_kind == bspe_pkg::KIND_NONE), (pair_energy == 48'sd0) && !saturated, "no-interaction result with energy")
	`BSPE_ASSERT_NOW(a_sat_at_limit, out_valid && saturated, (pair_energy == bspe_pkg::E_MAX) || (pair_energy == bspe_pkg::E_MIN), "saturated energy not at a limit")
	`BSPE_ASSERT_NOW(a_bond_nonneg, out_valid && (pair_kind == bspe_pkg::KIND_BOND), !pair_energy[47], "negative bond energy")
	`BSPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pair_energy) && $stable(pair_kind), "stalled result changed")

endmodule

bind bead_spring_pair_energy_top bspe_checker u_bspe_checker (.*);
